>>> hdl/lcsta_pkg.sv
// ----------------------------------------------------------------------------
// lcsta_pkg
// Shared types and constants for the load cell stability / tare / auto-zero
// block.
// ----------------------------------------------------------------------------
package lcsta_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int LIMIT_W     = 24;
    localparam int COUNT_W     = 8;
    localparam int GAIN_W      = 25;
    localparam int WEIGHT_W    = 26;
    localparam int GAIN_FRAC   = 24;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_ADDR_W  = 5;

    localparam int DEF_WINDOW_SIZE = 20;

    localparam logic [LIMIT_W-1:0] RST_STABILITY   = LIMIT_W'(2000);
    localparam logic [LIMIT_W-1:0] RST_MOVEMENT    = LIMIT_W'(4000);
    localparam logic [COUNT_W-1:0] RST_SETTLE      = COUNT_W'(5);
    localparam logic [LIMIT_W-1:0] RST_ZERO_WINDOW = LIMIT_W'(4265);
    localparam logic [COUNT_W-1:0] RST_ZERO_HOLD   = COUNT_W'(8);
    localparam logic               RST_AUTO_ZERO   = 1'b1;
    localparam logic [GAIN_W-1:0]  RST_GAIN        = GAIN_W'(393400);

    typedef enum logic [2:0] {
        REG_STABILITY,
        REG_MOVEMENT,
        REG_SETTLE,
        REG_ZERO_WINDOW,
        REG_ZERO_HOLD,
        REG_AUTO_ZERO,
        REG_GAIN
    } cfg_idx_t;

    typedef struct packed {
        logic [LIMIT_W-1:0] stability_limit;
        logic [LIMIT_W-1:0] movement_limit;
        logic [COUNT_W-1:0] settle_needed;
        logic [LIMIT_W-1:0] zero_window_counts;
        logic [COUNT_W-1:0] zero_hold_needed;
        logic               auto_zero_on;
        logic [GAIN_W-1:0]  gain_q24;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEED,
        ST_READ_PREV,
        ST_WRITE,
        ST_SCAN,
        ST_DIV,
        ST_UPDATE,
        ST_MUL,
        ST_OUT
    } state_t;

endpackage

>>> hdl/lcsta_if.sv
// ----------------------------------------------------------------------------
// lcsta_if
// Request and result channels of the load cell stability block.
// ----------------------------------------------------------------------------
interface lcsta_in_if;
    import lcsta_pkg::*;

    logic                          valid;
    logic                          ready;
    logic                          command;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, command, sample, input ready);
    modport sink   (input valid, command, sample, output ready);
endinterface

interface lcsta_out_if;
    import lcsta_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [WEIGHT_W-1:0]    weight_cg;
    logic signed [SAMPLE_BITS-1:0] window_average;
    logic                          is_steady;
    logic [COUNT_W-1:0]            settle_count;
    logic                          tare_valid;
    logic signed [SAMPLE_BITS-1:0] tare_counts;

    modport source (output valid, weight_cg, window_average, is_steady, settle_count,
                    tare_valid, tare_counts, input ready);
    modport sink   (input valid, weight_cg, window_average, is_steady, settle_count,
                    tare_valid, tare_counts, output ready);
endinterface

>>> hdl/load_cell_stability_tare_autozero.sv
// ----------------------------------------------------------------------------
// load_cell_stability_tare_autozero
// Window stability detect, tare capture and auto-zero tracking for load cell
// samples, with weight output in centigrams.
//
//   channel   role    carries
//   in_ch     sink    command, sample
//   out_ch    source  weight_cg, window_average, is_steady, settle_count,
//                     tare_valid, tare_counts
//   APB       slave   config registers at 4*index
//
// Sample request: a ring scan reads the whole window, and the divide by
// WINDOW_SIZE is one reciprocal multiply. The first sample after reset first
// seeds every ring entry with its own value.
// Tare request: goes straight to the output state. in_ch.ready is high only in idle.
// A result waits in the output register; a new request is taken meanwhile.
// Reset is asynchronous, active low; no clearing pass.
// ----------------------------------------------------------------------------
module load_cell_stability_tare_autozero #(
    parameter int WINDOW_SIZE = lcsta_pkg::DEF_WINDOW_SIZE
) (
    input  logic                                clk,
    input  logic                                rst_n,
    lcsta_in_if.sink                            in_ch,
    lcsta_out_if.source                         out_ch,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lcsta_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [lcsta_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [lcsta_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                                pready
);
    import lcsta_pkg::*;

    localparam int IDX_W  = $clog2(WINDOW_SIZE);
    localparam int CNT_W  = $clog2(WINDOW_SIZE + 1);
    localparam int SUM_W  = SAMPLE_BITS + $clog2(WINDOW_SIZE);
    localparam int RCP_SH = SAMPLE_BITS - 1 + 2 * $clog2(WINDOW_SIZE);
    localparam int RCP_W  = RCP_SH - $clog2(WINDOW_SIZE) + 1;
    localparam int RCP_PW = SUM_W + RCP_W;
    localparam int DIF_W  = SAMPLE_BITS + 1;
    localparam int PRD_W  = DIF_W + GAIN_W + 1;
    localparam int SH_W   = PRD_W - GAIN_FRAC;

    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(WINDOW_SIZE - 1);
    localparam logic [CNT_W-1:0] SEED_END  = CNT_W'(WINDOW_SIZE - 1);
    localparam logic [CNT_W-1:0] WIN_CNT   = CNT_W'(WINDOW_SIZE);
    localparam logic [RCP_W-1:0] RECIP     =
        RCP_W'(((64'd1 << RCP_SH) + 64'(WINDOW_SIZE - 1)) / 64'(WINDOW_SIZE));
    localparam logic [COUNT_W-1:0] SAT_CNT = '1;
    localparam logic signed [WEIGHT_W-1:0] W_MAX = {1'b0, {(WEIGHT_W-1){1'b1}}};
    localparam logic signed [WEIGHT_W-1:0] W_MIN = {1'b1, {(WEIGHT_W-1){1'b0}}};

    cfg_t cfg;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic [IDX_W-1:0]              ptr_reg, ptr_next;
    logic                          seeded_reg, seeded_next;
    logic [CNT_W-1:0]              seen_reg, seen_next;
    logic [COUNT_W-1:0]            steady_run_reg, steady_run_next;
    logic signed [SAMPLE_BITS-1:0] tare_level_reg, tare_level_next;
    logic                          tare_taken_reg, tare_taken_next;
    logic [COUNT_W-1:0]            zero_run_reg, zero_run_next;
    logic                          out_valid_reg, out_valid_next;

    logic signed [SAMPLE_BITS-1:0] raw_reg, raw_next;
    logic                          tare_cmd_reg, tare_cmd_next;
    logic signed [SAMPLE_BITS-1:0] prev_reg, prev_next;
    logic signed [SUM_W-1:0]       sum_reg, sum_next;
    logic signed [SAMPLE_BITS-1:0] mn_reg, mn_next;
    logic signed [SAMPLE_BITS-1:0] mx_reg, mx_next;
    logic [SUM_W-1:0]              quo_reg, quo_next;
    logic                          neg_reg, neg_next;
    logic signed [SAMPLE_BITS-1:0] avg_reg, avg_next;
    logic                          steady_reg, steady_next;
    logic signed [PRD_W-1:0]       prod_reg, prod_next;

    logic signed [WEIGHT_W-1:0]    o_weight_reg, o_weight_next;
    logic signed [SAMPLE_BITS-1:0] o_avg_reg, o_avg_next;
    logic                          o_steady_reg, o_steady_next;
    logic [COUNT_W-1:0]            o_settle_reg, o_settle_next;
    logic                          o_tvalid_reg, o_tvalid_next;
    logic signed [SAMPLE_BITS-1:0] o_tare_reg, o_tare_next;

    logic                    ram_we;
    logic [IDX_W-1:0]        ram_waddr;
    logic [IDX_W-1:0]        ram_raddr;
    logic [SAMPLE_BITS-1:0]  ram_rdata;
    logic signed [SAMPLE_BITS-1:0] rd_s;
    logic                    in_take;
    logic                    out_load;

    // datapath helpers
    logic signed [SUM_W-1:0]       sum_acc;
    logic [RCP_PW-1:0]             rcp_prod;
    logic [SUM_W-1:0]              rcp_quo;
    logic signed [DIF_W-1:0]       spread;
    logic signed [DIF_W-1:0]       jump;
    logic [DIF_W-1:0]              jump_abs;
    logic signed [DIF_W-1:0]       zdist;
    logic [DIF_W-1:0]              zdist_abs;
    logic signed [SAMPLE_BITS-1:0] avg_c;
    logic                          steady_c;
    logic [COUNT_W-1:0]            run_c;
    logic [COUNT_W-1:0]            zrun_inc;
    logic signed [DIF_W-1:0]       wdiff_new;
    logic signed [SH_W-1:0]        shifted;
    logic                          w_ovf;

    lcsta_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lcsta_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (WINDOW_SIZE)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (raw_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_s = $signed(ram_rdata);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    if (in_ch.command)
                        state_next = ST_OUT;
                    else if (seeded_reg)
                        state_next = ST_READ_PREV;
                    else
                        state_next = ST_SEED;
                end
            end
            ST_SEED:      if (cnt_reg == SEED_END) state_next = ST_READ_PREV;
            ST_READ_PREV: state_next = ST_WRITE;
            ST_WRITE:     state_next = ST_SCAN;
            ST_SCAN:      if (cnt_reg == WIN_CNT) state_next = ST_DIV;
            ST_DIV:       state_next = ST_UPDATE;
            ST_UPDATE:    state_next = ST_MUL;
            ST_MUL:       state_next = ST_OUT;
            ST_OUT:       if (!out_valid_reg || out_ch.ready) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        in_ch.ready = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = ptr_reg;
        ram_raddr   = ptr_reg;
        out_load    = 1'b0;
        case (state_reg)
            ST_IDLE:      in_ch.ready = 1'b1;
            ST_SEED:
            begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg[IDX_W-1:0];
            end
            ST_READ_PREV: ram_raddr = ptr_reg;
            ST_WRITE:     ram_we = 1'b1;
            ST_SCAN:      ram_raddr = cnt_reg[IDX_W-1:0];
            ST_OUT:       out_load = !out_valid_reg || out_ch.ready;
            default:      in_ch.ready = 1'b0;
        endcase
    end

    assign in_take = in_ch.valid && in_ch.ready;

    // combinational arithmetic
    always_comb
    begin
        sum_acc   = sum_reg + {{(SUM_W-SAMPLE_BITS){rd_s[SAMPLE_BITS-1]}}, rd_s};
        // magnitude / WINDOW_SIZE by reciprocal multiply, exact over the sum range
        rcp_prod  = RCP_PW'(quo_reg) * RCP_PW'(RECIP);
        rcp_quo   = SUM_W'(rcp_prod >> RCP_SH);
        avg_c     = neg_reg ? -$signed(quo_reg[SAMPLE_BITS-1:0])
                            : $signed(quo_reg[SAMPLE_BITS-1:0]);
        spread    = {mx_reg[SAMPLE_BITS-1], mx_reg} - {mn_reg[SAMPLE_BITS-1], mn_reg};
        steady_c  = (seen_reg == WIN_CNT) &&
                    ($unsigned(spread) < {1'b0, cfg.stability_limit});
        jump      = {raw_reg[SAMPLE_BITS-1], raw_reg} - {prev_reg[SAMPLE_BITS-1], prev_reg};
        jump_abs  = jump[DIF_W-1] ? $unsigned(-jump) : $unsigned(jump);
        zdist     = {avg_reg[SAMPLE_BITS-1], avg_reg}
                  - {tare_level_reg[SAMPLE_BITS-1], tare_level_reg};
        zdist_abs = zdist[DIF_W-1] ? $unsigned(-zdist) : $unsigned(zdist);
        if (jump_abs > {1'b0, cfg.movement_limit})
            run_c = '0;
        else if (steady_c)
            run_c = (steady_run_reg == SAT_CNT) ? steady_run_reg : steady_run_reg + 1'b1;
        else
            run_c = '0;
        zrun_inc  = (zero_run_reg == SAT_CNT) ? zero_run_reg : zero_run_reg + 1'b1;
        shifted   = prod_reg[PRD_W-1:GAIN_FRAC];
        w_ovf     = !((&shifted[SH_W-1:WEIGHT_W-1]) || !(|shifted[SH_W-1:WEIGHT_W-1]));
    end

    // datapath next values
    always_comb
    begin
        cnt_next        = cnt_reg;
        ptr_next        = ptr_reg;
        seeded_next     = seeded_reg;
        seen_next       = seen_reg;
        steady_run_next = steady_run_reg;
        tare_level_next = tare_level_reg;
        tare_taken_next = tare_taken_reg;
        zero_run_next   = zero_run_reg;
        raw_next        = raw_reg;
        tare_cmd_next   = tare_cmd_reg;
        prev_next       = prev_reg;
        sum_next        = sum_reg;
        mn_next         = mn_reg;
        mx_next         = mx_reg;
        quo_next        = quo_reg;
        neg_next        = neg_reg;
        avg_next        = avg_reg;
        steady_next     = steady_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (in_take)
                begin
                    raw_next      = in_ch.sample;
                    tare_cmd_next = in_ch.command;
                    if (in_ch.command)
                    begin
                        tare_taken_next = 1'b0;
                        steady_run_next = '0;
                    end
                end
            end
            ST_SEED:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == SEED_END)
                    seeded_next = 1'b1;
            end
            ST_WRITE:
            begin
                prev_next = rd_s;
                ptr_next  = (ptr_reg == LAST_IDX) ? '0 : ptr_reg + 1'b1;
                if (seen_reg != WIN_CNT)
                    seen_next = seen_reg + 1'b1;
                cnt_next  = '0;
            end
            ST_SCAN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    sum_next = {{(SUM_W-SAMPLE_BITS){rd_s[SAMPLE_BITS-1]}}, rd_s};
                    mn_next  = rd_s;
                    mx_next  = rd_s;
                end
                else if (cnt_reg != '0)
                begin
                    sum_next = sum_acc;
                    if (rd_s < mn_reg) mn_next = rd_s;
                    if (rd_s > mx_reg) mx_next = rd_s;
                end
                if (cnt_reg == WIN_CNT)
                begin
                    neg_next = sum_acc[SUM_W-1];
                    quo_next = sum_acc[SUM_W-1] ? $unsigned(-sum_acc) : $unsigned(sum_acc);
                end
            end
            ST_DIV:
            begin
                quo_next = rcp_quo;
            end
            ST_UPDATE:
            begin
                avg_next        = avg_c;
                steady_next     = steady_c;
                steady_run_next = run_c;
            end
            ST_MUL:
            begin
                // tare/auto-zero decision uses the settled average
                if (steady_run_reg >= cfg.settle_needed)
                begin
                    if (!tare_taken_reg)
                    begin
                        tare_level_next = avg_reg;
                        tare_taken_next = 1'b1;
                    end
                    else if (cfg.auto_zero_on)
                    begin
                        if (zdist_abs < {1'b0, cfg.zero_window_counts})
                        begin
                            if (zrun_inc >= cfg.zero_hold_needed)
                            begin
                                tare_level_next = avg_reg;
                                zero_run_next   = '0;
                            end
                            else
                            begin
                                zero_run_next = zrun_inc;
                            end
                        end
                        else
                        begin
                            zero_run_next = '0;
                        end
                    end
                end
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    // the product needs the tare after the decision
    assign wdiff_new = {raw_reg[SAMPLE_BITS-1], raw_reg}
                     - {tare_level_next[SAMPLE_BITS-1], tare_level_next};

    always_comb
    begin
        if (state_reg == ST_MUL)
            prod_next = PRD_W'(wdiff_new) * PRD_W'($signed({1'b0, cfg.gain_q24}));
        else
            prod_next = prod_reg;
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ch.ready;
        o_weight_next  = o_weight_reg;
        o_avg_next     = o_avg_reg;
        o_steady_next  = o_steady_reg;
        o_settle_next  = o_settle_reg;
        o_tvalid_next  = o_tvalid_reg;
        o_tare_next    = o_tare_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            o_tare_next    = tare_level_reg;
            o_tvalid_next  = tare_taken_reg;
            o_settle_next  = steady_run_reg;
            if (tare_cmd_reg)
            begin
                o_weight_next = '0;
                o_avg_next    = '0;
                o_steady_next = 1'b0;
            end
            else
            begin
                o_avg_next    = avg_reg;
                o_steady_next = steady_reg;
                if (w_ovf)
                    o_weight_next = shifted[SH_W-1] ? W_MIN : W_MAX;
                else
                    o_weight_next = shifted[WEIGHT_W-1:0];
            end
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.weight_cg      = o_weight_reg;
    assign out_ch.window_average = o_avg_reg;
    assign out_ch.is_steady      = o_steady_reg;
    assign out_ch.settle_count   = o_settle_reg;
    assign out_ch.tare_valid     = o_tvalid_reg;
    assign out_ch.tare_counts    = o_tare_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            ptr_reg        <= '0;
            seeded_reg     <= 1'b0;
            seen_reg       <= '0;
            steady_run_reg <= '0;
            tare_level_reg <= '0;
            tare_taken_reg <= 1'b0;
            zero_run_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            ptr_reg        <= ptr_next;
            seeded_reg     <= seeded_next;
            seen_reg       <= seen_next;
            steady_run_reg <= steady_run_next;
            tare_level_reg <= tare_level_next;
            tare_taken_reg <= tare_taken_next;
            zero_run_reg   <= zero_run_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        raw_reg      <= raw_next;
        tare_cmd_reg <= tare_cmd_next;
        prev_reg     <= prev_next;
        sum_reg      <= sum_next;
        mn_reg       <= mn_next;
        mx_reg       <= mx_next;
        quo_reg      <= quo_next;
        neg_reg      <= neg_next;
        avg_reg      <= avg_next;
        steady_reg   <= steady_next;
        prod_reg     <= prod_next;
        o_weight_reg <= o_weight_next;
        o_avg_reg    <= o_avg_next;
        o_steady_reg <= o_steady_next;
        o_settle_reg <= o_settle_next;
        o_tvalid_reg <= o_tvalid_next;
        o_tare_reg   <= o_tare_next;
    end

endmodule

>>> hdl/lcsta_ram.sv
// ----------------------------------------------------------------------------
// lcsta_ram
// Generic single write / single read RAM with registered read data.
// ----------------------------------------------------------------------------
module lcsta_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 20
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hdl/lcsta_cfg.sv
// ----------------------------------------------------------------------------
// lcsta_cfg
// APB-style configuration register bank.
// ----------------------------------------------------------------------------
module lcsta_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lcsta_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [lcsta_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [lcsta_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                                pready,
    output lcsta_pkg::cfg_t                     cfg
);
    import lcsta_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    cfg_idx_t idx;
    logic     wr_en;

    assign idx    = cfg_idx_t'(paddr[CFG_ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_STABILITY:   cfg_next.stability_limit    = pwdata[LIMIT_W-1:0];
                REG_MOVEMENT:    cfg_next.movement_limit     = pwdata[LIMIT_W-1:0];
                REG_SETTLE:      cfg_next.settle_needed      = pwdata[COUNT_W-1:0];
                REG_ZERO_WINDOW: cfg_next.zero_window_counts = pwdata[LIMIT_W-1:0];
                REG_ZERO_HOLD:   cfg_next.zero_hold_needed   = pwdata[COUNT_W-1:0];
                REG_AUTO_ZERO:   cfg_next.auto_zero_on       = pwdata[0];
                REG_GAIN:        cfg_next.gain_q24           = pwdata[GAIN_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_STABILITY:   prdata = CFG_DATA_W'(cfg_reg.stability_limit);
            REG_MOVEMENT:    prdata = CFG_DATA_W'(cfg_reg.movement_limit);
            REG_SETTLE:      prdata = CFG_DATA_W'(cfg_reg.settle_needed);
            REG_ZERO_WINDOW: prdata = CFG_DATA_W'(cfg_reg.zero_window_counts);
            REG_ZERO_HOLD:   prdata = CFG_DATA_W'(cfg_reg.zero_hold_needed);
            REG_AUTO_ZERO:   prdata = CFG_DATA_W'(cfg_reg.auto_zero_on);
            REG_GAIN:        prdata = CFG_DATA_W'(cfg_reg.gain_q24);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stability_limit    <= RST_STABILITY;
            cfg_reg.movement_limit     <= RST_MOVEMENT;
            cfg_reg.settle_needed      <= RST_SETTLE;
            cfg_reg.zero_window_counts <= RST_ZERO_WINDOW;
            cfg_reg.zero_hold_needed   <= RST_ZERO_HOLD;
            cfg_reg.auto_zero_on       <= RST_AUTO_ZERO;
            cfg_reg.gain_q24           <= RST_GAIN;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> verif/tb_load_cell_stability_tare_autozero.sv
// ----------------------------------------------------------------------------
// tb_load_cell_stability_tare_autozero
// Drives sample and tare requests with random gaps, random result stalls and
// several register settings (reset values, tight and loose extremes, a long
// saturating settle run, random settings). A local predictor of the window,
// settle count, tare and auto-zero logic checks every result field by field.
// ----------------------------------------------------------------------------
module tb_load_cell_stability_tare_autozero;
    import lcsta_pkg::*;

    localparam int WINDOW          = DEF_WINDOW_SIZE;
    localparam int UNUSED_REG_IDX  = 7;
    localparam int END_DRAIN       = 2 * (WINDOW + 60);
    localparam int WATCHDOG_LIMIT  = 5000;

    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = 24'sh7FFFFF;
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = 24'sh800000;

    localparam cfg_t RESET_CFG = '{
        stability_limit:    RST_STABILITY,
        movement_limit:     RST_MOVEMENT,
        settle_needed:      RST_SETTLE,
        zero_window_counts: RST_ZERO_WINDOW,
        zero_hold_needed:   RST_ZERO_HOLD,
        auto_zero_on:       RST_AUTO_ZERO,
        gain_q24:           RST_GAIN
    };

    typedef enum logic {
        CMD_SAMPLE = 1'b0,
        CMD_TARE   = 1'b1
    } request_cmd_t;

    typedef struct {
        logic signed [WEIGHT_W-1:0]    weight_cg;
        logic signed [SAMPLE_BITS-1:0] window_average;
        logic                          is_steady;
        logic [COUNT_W-1:0]            settle_count;
        logic                          tare_valid;
        logic signed [SAMPLE_BITS-1:0] tare_counts;
    } reading_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    lcsta_in_if  in_ch ();
    lcsta_out_if out_ch ();

    load_cell_stability_tare_autozero uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #1 clk = ~clk;

    // predictor state
    cfg_t   cfg = RESET_CFG;
    longint ring_val [WINDOW];
    int     ring_pos      = 0;
    bit     ring_filled   = 1'b0;
    int     seen_count    = 0;
    int     settle_run    = 0;
    longint tare_cnt      = 0;
    bit     tare_held     = 1'b0;
    int     near_zero_run = 0;

    reading_t pending_readings [$];
    bit       no_idle = 1'b0;
    int       failures = 0;
    int       n_requests = 0;
    int       n_tare_requests = 0;
    int       n_checked = 0;
    int       n_steady = 0;
    int       n_tare_moves = 0;
    int       quiet_cycles = 0;

    function automatic reading_t weigh_request(input request_cmd_t cmd,
                                               input logic signed [SAMPLE_BITS-1:0] smp);
        reading_t r;
        longint   raw;
        longint   prev;
        longint   sum;
        longint   lo;
        longint   hi;
        longint   avg;
        longint   jump;
        longint   off;
        longint   w;
        bit       steady;
        n_requests++;
        if (cmd == CMD_TARE)
        begin
            n_tare_requests++;
            tare_held  = 1'b0;
            settle_run = 0;
            r.weight_cg      = '0;
            r.window_average = '0;
            r.is_steady      = 1'b0;
            r.settle_count   = '0;
            r.tare_valid     = 1'b0;
            r.tare_counts    = tare_cnt[SAMPLE_BITS-1:0];
            return r;
        end
        raw = smp;
        if (!ring_filled)
        begin
            foreach (ring_val[i]) ring_val[i] = raw;
            ring_filled = 1'b1;
        end
        prev = ring_val[ring_pos];
        ring_val[ring_pos] = raw;
        ring_pos = (ring_pos + 1) % WINDOW;
        if (seen_count < WINDOW) seen_count++;

        sum = 0;
        lo  = ring_val[0];
        hi  = ring_val[0];
        foreach (ring_val[i])
        begin
            sum += ring_val[i];
            if (ring_val[i] < lo) lo = ring_val[i];
            if (ring_val[i] > hi) hi = ring_val[i];
        end
        avg = sum / WINDOW;
        steady = (seen_count >= WINDOW) && ((hi - lo) < longint'(cfg.stability_limit));
        if (steady) n_steady++;

        jump = raw - prev;
        if (jump < 0) jump = -jump;
        if (jump > longint'(cfg.movement_limit))
            settle_run = 0;
        else if (steady)
        begin
            if (settle_run < 255) settle_run++;
        end
        else
            settle_run = 0;

        if (settle_run >= cfg.settle_needed)
        begin
            if (!tare_held)
            begin
                tare_cnt  = avg;
                tare_held = 1'b1;
                n_tare_moves++;
            end
            else if (cfg.auto_zero_on)
            begin
                off = avg - tare_cnt;
                if (off < 0) off = -off;
                if (off < longint'(cfg.zero_window_counts))
                begin
                    if (near_zero_run < 255) near_zero_run++;
                    if (near_zero_run >= cfg.zero_hold_needed)
                    begin
                        tare_cnt      = avg;
                        near_zero_run = 0;
                        n_tare_moves++;
                    end
                end
                else
                    near_zero_run = 0;
            end
        end

        w = ((raw - tare_cnt) * longint'(cfg.gain_q24)) >>> GAIN_FRAC;
        if (w > 33554431) w = 33554431;
        if (w < -33554432) w = -33554432;

        r.weight_cg      = w[WEIGHT_W-1:0];
        r.window_average = avg[SAMPLE_BITS-1:0];
        r.is_steady      = steady;
        r.settle_count   = COUNT_W'(settle_run);
        r.tare_valid     = tare_held;
        r.tare_counts    = tare_cnt[SAMPLE_BITS-1:0];
        return r;
    endfunction

    function automatic void note_mismatch(input string what,
                                          input logic signed [31:0] want,
                                          input logic signed [31:0] got);
        if (got !== want)
        begin
            failures++;
            if (failures <= 10)
                $display("mismatch in result %0d, %s: expected %0d, got %0d",
                         n_checked, what, want, got);
        end
    endfunction

    task automatic check_reading();
        reading_t want;
        n_checked++;
        if (pending_readings.size() == 0)
        begin
            failures++;
            if (failures <= 10)
                $display("result %0d arrived with no request outstanding", n_checked);
            return;
        end
        want = pending_readings.pop_front();
        note_mismatch("weight_cg",      want.weight_cg,      out_ch.weight_cg);
        note_mismatch("window_average", want.window_average, out_ch.window_average);
        note_mismatch("is_steady",      want.is_steady,      out_ch.is_steady);
        note_mismatch("settle_count",   want.settle_count,   out_ch.settle_count);
        note_mismatch("tare_valid",     want.tare_valid,     out_ch.tare_valid);
        note_mismatch("tare_counts",    want.tare_counts,    out_ch.tare_counts);
    endtask

    initial
    begin
        int stall;
        out_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 3);
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (out_ch.valid !== 1'b1);
            check_reading();
        end
    end

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no request or result moved for %0d cycles", quiet_cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_request(input request_cmd_t cmd,
                                input logic signed [SAMPLE_BITS-1:0] smp);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.command <= cmd;
        in_ch.sample  <= smp;
        do @(posedge clk); while (in_ch.ready !== 1'b1);
        pending_readings.push_back(weigh_request(cmd, smp));
    endtask

    task automatic wait_all_readings();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (pending_readings.size() != 0);
    endtask

    // penable drops after each access; psel stays up across a burst of writes
    task automatic write_reg(input int idx, input logic [CFG_DATA_W-1:0] value);
        psel   <= 1'b1;
        pwrite <= 1'b1;
        paddr  <= CFG_ADDR_W'(idx * 4);
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        penable <= 1'b0;
        case (idx)
            REG_STABILITY:   cfg.stability_limit    = value[LIMIT_W-1:0];
            REG_MOVEMENT:    cfg.movement_limit     = value[LIMIT_W-1:0];
            REG_SETTLE:      cfg.settle_needed      = value[COUNT_W-1:0];
            REG_ZERO_WINDOW: cfg.zero_window_counts = value[LIMIT_W-1:0];
            REG_ZERO_HOLD:   cfg.zero_hold_needed   = value[COUNT_W-1:0];
            REG_AUTO_ZERO:   cfg.auto_zero_on       = value[0];
            REG_GAIN:        cfg.gain_q24           = value[GAIN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input cfg_t s);
        write_reg(REG_STABILITY,   {8'($urandom), s.stability_limit});
        write_reg(REG_MOVEMENT,    {8'($urandom), s.movement_limit});
        write_reg(REG_SETTLE,      {24'($urandom), s.settle_needed});
        write_reg(REG_ZERO_WINDOW, {8'($urandom), s.zero_window_counts});
        write_reg(REG_ZERO_HOLD,   {24'($urandom), s.zero_hold_needed});
        write_reg(REG_AUTO_ZERO,   {31'($urandom), s.auto_zero_on});
        write_reg(REG_GAIN,        {7'($urandom), s.gain_q24});
        write_reg(UNUSED_REG_IDX,  $urandom);
        psel   <= 1'b0;
        pwrite <= 1'b0;
    endtask

    function automatic longint jitter(input int amp);
        return longint'($urandom_range(0, 2 * amp)) - longint'(amp);
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] to_sample(input longint v);
        if (v > 8388607) v = 8388607;
        if (v < -8388608) v = -8388608;
        return v[SAMPLE_BITS-1:0];
    endfunction

    // runs of samples around one level so the window settles, with tare
    // requests, wild samples and one full drain mixed in
    task automatic drive_weighing_runs(input int n_items);
        int     sent;
        int     run_len;
        int     noise;
        int     zw;
        int     pick;
        longint level;
        sent = 0;
        while (sent < n_items)
        begin
            no_idle = ($urandom_range(0, 3) == 0);
            run_len = $urandom_range(4, 60);
            zw = (cfg.zero_window_counts > 3000) ? 3000 : int'(cfg.zero_window_counts);
            case ($urandom_range(0, 4))
                0: level = longint'($signed(SAMPLE_BITS'($urandom)));
                1: level = tare_cnt + jitter(zw);
                2: level = $urandom_range(0, 1) ? 8388607 - jitter(200) - 200
                                                 : -8388608 + jitter(200) + 200;
                default: level = jitter(10000);
            endcase
            noise = ($urandom_range(0, 3) == 0) ? 5000 : $urandom_range(0, 600);
            for (int k = 0; k < run_len && sent < n_items; k++)
            begin
                pick = $urandom_range(0, 31);
                if (pick == 0)
                    send_request(CMD_TARE, SAMPLE_BITS'($urandom));
                else if (pick == 1)
                    send_request(CMD_SAMPLE, SAMPLE_BITS'($urandom));
                else
                    send_request(CMD_SAMPLE, to_sample(level + jitter(noise)));
                sent++;
                if (sent == n_items / 2) wait_all_readings();
            end
        end
        no_idle = 1'b0;
        wait_all_readings();
    endtask

    task automatic test_reset_values_directed();
        send_request(CMD_TARE, SAMPLE_BITS'($urandom));
        send_request(CMD_SAMPLE, SAMPLE_MAX);
        send_request(CMD_SAMPLE, SAMPLE_MIN);
        send_request(CMD_SAMPLE, -24'sd1);
        send_request(CMD_SAMPLE, 24'sd0);
        send_request(CMD_SAMPLE, 24'sd1);
        repeat (17) send_request(CMD_SAMPLE, 24'sd5000);
        send_request(CMD_TARE, SAMPLE_MIN);
        send_request(CMD_SAMPLE, -24'sd5000);
        wait_all_readings();
    endtask

    task automatic test_register_extremes();
        apply_settings('{stability_limit: '0, movement_limit: '0, settle_needed: 8'd1,
                         zero_window_counts: '0, zero_hold_needed: 8'd1,
                         auto_zero_on: 1'b0, gain_q24: '0});
        drive_weighing_runs(100);
        apply_settings('{stability_limit: '1, movement_limit: '1, settle_needed: 8'd1,
                         zero_window_counts: '1, zero_hold_needed: 8'd1,
                         auto_zero_on: 1'b1, gain_q24: GAIN_W'(1 << GAIN_FRAC)});
        drive_weighing_runs(200);
    endtask

    task automatic test_settle_saturation();
        longint level;
        apply_settings('{stability_limit: '1, movement_limit: '1, settle_needed: 8'd255,
                         zero_window_counts: '1, zero_hold_needed: 8'd255,
                         auto_zero_on: 1'b1, gain_q24: GAIN_W'($urandom_range(0, 1 << 24))});
        level = jitter(8000000);
        repeat (300) send_request(CMD_SAMPLE, to_sample(level + jitter(2000)));
        send_request(CMD_TARE, SAMPLE_BITS'($urandom));
        wait_all_readings();
    endtask

    task automatic test_random_settings();
        cfg_t s;
        repeat (2)
        begin
            s.stability_limit    = $urandom_range(0, 1) ? LIMIT_W'($urandom_range(200, 4000))
                                                        : LIMIT_W'($urandom);
            s.movement_limit     = $urandom_range(0, 1) ? LIMIT_W'($urandom_range(500, 8000))
                                                        : LIMIT_W'($urandom);
            s.settle_needed      = COUNT_W'($urandom_range(1, 8));
            s.zero_window_counts = LIMIT_W'($urandom_range(0, 8000));
            s.zero_hold_needed   = COUNT_W'($urandom_range(1, 12));
            s.auto_zero_on       = 1'($urandom_range(0, 1));
            s.gain_q24           = GAIN_W'($urandom_range(0, 1 << 24));
            apply_settings(s);
            drive_weighing_runs(200);
        end
    endtask

    task automatic test_default_settings();
        apply_settings(RESET_CFG);
        drive_weighing_runs(150);
    endtask

    initial
    begin
        foreach (ring_val[i]) ring_val[i] = 0;
        rst_n         <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.command <= CMD_SAMPLE;
        in_ch.sample  <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_values_directed();
        test_register_extremes();
        test_settle_saturation();
        test_random_settings();
        test_default_settings();

        wait_all_readings();
        repeat (END_DRAIN) @(posedge clk);
        if (pending_readings.size() != 0)
        begin
            failures++;
            $display("%0d results never arrived", pending_readings.size());
        end
        $display("%0d requests (%0d tare), %0d results checked, %0d failures",
                 n_requests, n_tare_requests, n_checked, failures);
        $display("cfg sets: reset, tight, loose, saturating, random; %0d steady, %0d tare moves",
                 n_steady, n_tare_moves);
        if (failures == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> filelist.f
hdl/lcsta_pkg.sv
hdl/lcsta_if.sv
hdl/lcsta_ram.sv
hdl/lcsta_cfg.sv
hdl/load_cell_stability_tare_autozero.sv
verif/tb_load_cell_stability_tare_autozero.sv
